// ----- sv/crm_pkg.sv -----
// crm_pkg: shared types, codes and field layout for the coalescing request mailbox.
// Used by crm_counters and coalescing_request_mailbox. No dependencies.
package crm_pkg;

  // Default sizes of the internal storage
  localparam int TagWidthDef   = 32;
  localparam int CountWidthDef = 32;
  localparam int LevelWidthDef = 8;
  localparam int LevelMaxReset = 255;

  // Field widths on the stream ports
  localparam int ACTION_W    = 3;
  localparam int TAG_FIELD_W = 32;
  localparam int LEVEL_FLD_W = 8;
  localparam int KIND_W      = 2;
  localparam int SPARE_W     = 8;
  localparam int STATUS_W    = 3;
  localparam int STAT_SEL_W  = 4;
  localparam int RESULT_W    = 4;
  localparam int STAT_VAL_W  = 32;

  // Input tdata layout, lowest field first
  localparam int IN_ACTION_LO = 0;
  localparam int IN_SESS_LO   = IN_ACTION_LO + ACTION_W;
  localparam int IN_REQ_LO    = IN_SESS_LO + TAG_FIELD_W;
  localparam int IN_GEN_LO    = IN_REQ_LO + TAG_FIELD_W;
  localparam int IN_SEQ_LO    = IN_GEN_LO + TAG_FIELD_W;
  localparam int IN_LEVEL_LO  = IN_SEQ_LO + TAG_FIELD_W;
  localparam int IN_KIND_LO   = IN_LEVEL_LO + LEVEL_FLD_W;
  localparam int IN_SPARE_LO  = IN_KIND_LO + KIND_W;
  localparam int IN_STATUS_LO = IN_SPARE_LO + SPARE_W;
  localparam int IN_STSEL_LO  = IN_STATUS_LO + STATUS_W;
  localparam int IN_BITS      = IN_STSEL_LO + STAT_SEL_W;
  localparam int S_TDATA_W    = ((IN_BITS + 7) / 8) * 8;

  // Output tdata layout, lowest field first (entry_valid travels in tuser)
  localparam int OUT_BITS  = RESULT_W + 4 * TAG_FIELD_W + LEVEL_FLD_W + 1 + STAT_VAL_W;
  localparam int M_TDATA_W = ((OUT_BITS + 7) / 8) * 8;
  localparam int OUT_PAD_W = M_TDATA_W - OUT_BITS;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [ACTION_W-1:0] {
    ACT_POST     = 3'd0,
    ACT_TAKE     = 3'd1,
    ACT_COMPLETE = 3'd2,
    ACT_NOTE     = 3'd3,
    ACT_STAT     = 3'd4,
    ACT_CHECK    = 3'd5
  } action_t;

  typedef enum logic [RESULT_W-1:0] {
    RES_ACCEPTED = 4'd0,
    RES_REPLACED = 4'd1,
    RES_STALE    = 4'd2,
    RES_INVALID  = 4'd3,
    RES_READY    = 4'd4,
    RES_EMPTY    = 4'd5,
    RES_BUSY     = 4'd6,
    RES_TRUE     = 4'd7,
    RES_FALSE    = 4'd8,
    RES_STAT     = 4'd9
  } result_t;

  // Event counter slots
  localparam int NUM_CNT = 9;
  typedef enum logic [3:0] {
    CNT_STALE     = 4'd0,
    CNT_POSTED    = 4'd1,
    CNT_REPLACED  = 4'd2,
    CNT_TAKEN     = 4'd3,
    CNT_COMPLETED = 4'd4,
    CNT_OK        = 4'd5,
    CNT_BUSY      = 4'd6,
    CNT_TIMEOUT   = 4'd7,
    CNT_FAILED    = 4'd8
  } cnt_idx_t;

  // Readable statistics
  typedef enum logic [STAT_SEL_W-1:0] {
    ST_PENDING   = 4'd0,
    ST_FLIGHT    = 4'd1,
    ST_LAST_SEQ  = 4'd2,
    ST_POSTED    = 4'd3,
    ST_REPLACED  = 4'd4,
    ST_STALE     = 4'd5,
    ST_TAKEN     = 4'd6,
    ST_COMPLETED = 4'd7,
    ST_OK        = 4'd8,
    ST_BUSY      = 4'd9,
    ST_TIMEOUT   = 4'd10,
    ST_FAILED    = 4'd11
  } stat_sel_t;

  // Configuration register indexes (byte address / 4)
  typedef enum logic {
    REG_LEVEL_MIN = 1'b0,
    REG_LEVEL_MAX = 1'b1
  } cfg_reg_t;

endpackage

// ----- sv/crm_counters.sv -----
// crm_counters: bank of saturating event counters for the mailbox.
// Depends on crm_pkg for the counter count.
module crm_counters #(
  parameter int COUNT_WIDTH = crm_pkg::CountWidthDef
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [crm_pkg::NUM_CNT-1:0] inc,
  output logic [COUNT_WIDTH-1:0] count [crm_pkg::NUM_CNT]
);
  import crm_pkg::*;

  for (genvar i = 0; i < NUM_CNT; i++) begin : g_cnt
    always_ff @(posedge clk) begin
      if (rst) begin
        count[i] <= '0;
      end else if (inc[i] && (count[i] != {COUNT_WIDTH{1'b1}})) begin
        count[i] <= count[i] + COUNT_WIDTH'(1);
      end
    end
  end

endmodule

// ----- sv/coalescing_request_mailbox.sv -----
// coalescing_request_mailbox: top level of the latest-wins brightness request mailbox.
// Depends on crm_pkg and crm_counters.
//
// Usage:
//   Commands arrive on the s_ stream channel, one per transfer (post, take,
//   complete, note apply, read stat, check in-flight). Each command yields
//   exactly one result transfer on the m_ channel; m_tuser flags that the
//   returned entry fields carry a replaced or taken request.
//   level_min/level_max sit on the APB port at byte addresses 0 and 4; write
//   them only while no command is outstanding.
//   A command passes through one input register, then the decision logic
//   feeding the result register, before it reaches m_tvalid.
//   Throughput is one command per cycle while m_tready does not hold the
//   result register; the slot and counter updates all land in the single
//   result cycle, so back-to-back commands see each other's effects.
//   When m_tvalid is high and m_tready is low the result register holds;
//   s_tready stays high only while the input register is empty, so at most
//   one more command is taken into it before s_tready drops.
//   Reset empties both slots, clears the last sequence number and all
//   counters, and restores level_min to 0 and level_max to 255.
module coalescing_request_mailbox #(
  parameter int TAG_WIDTH   = crm_pkg::TagWidthDef,
  parameter int COUNT_WIDTH = crm_pkg::CountWidthDef,
  parameter int LEVEL_WIDTH = crm_pkg::LevelWidthDef
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // action, session_tag, request_tag, generation_tag, sequence_no, level,
  // kind, spare_bits, apply_status, stat_index
  input  logic [crm_pkg::S_TDATA_W-1:0]      s_tdata,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // result_code, out_session, out_request, out_generation, out_sequence,
  // out_level, out_kind, stat_value
  output logic [crm_pkg::M_TDATA_W-1:0]      m_tdata,
  // entry_valid
  output logic                               m_tuser,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [crm_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [crm_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic [crm_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                               pready
);
  import crm_pkg::*;

  // Configuration
  logic [LEVEL_WIDTH-1:0] level_min;
  logic [LEVEL_WIDTH-1:0] level_max;
  logic                   cfg_write;
  cfg_reg_t               cfg_sel;

  assign pready    = 1'b1;
  assign cfg_sel   = cfg_reg_t'(paddr[2]);
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      level_min <= '0;
      level_max <= LEVEL_WIDTH'(LevelMaxReset);
    end else if (cfg_write) begin
      case (cfg_sel)
        REG_LEVEL_MIN: level_min <= LEVEL_WIDTH'(pwdata);
        REG_LEVEL_MAX: level_max <= LEVEL_WIDTH'(pwdata);
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_sel)
      REG_LEVEL_MIN: prdata = CFG_DATA_W'(level_min);
      REG_LEVEL_MAX: prdata = CFG_DATA_W'(level_max);
      default:       prdata = '0;
    endcase
  end

  // Input register
  logic                  in_valid;
  logic [S_TDATA_W-1:0]  in_data;
  logic                  advance;

  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_data <= s_tdata;
    end
  end

  // Field unpacking
  logic [ACTION_W-1:0]    req_action;
  logic [TAG_WIDTH-1:0]   req_session;
  logic [TAG_WIDTH-1:0]   req_request;
  logic [TAG_WIDTH-1:0]   req_generation;
  logic [TAG_WIDTH-1:0]   req_sequence;
  logic [LEVEL_WIDTH-1:0] req_level;
  logic [KIND_W-1:0]      req_kind;
  logic [SPARE_W-1:0]     req_spare;
  logic [STATUS_W-1:0]    req_status;
  logic [STAT_SEL_W-1:0]  req_stat_sel;

  assign req_action     = in_data[IN_ACTION_LO +: ACTION_W];
  assign req_session    = TAG_WIDTH'(in_data[IN_SESS_LO +: TAG_FIELD_W]);
  assign req_request    = TAG_WIDTH'(in_data[IN_REQ_LO +: TAG_FIELD_W]);
  assign req_generation = TAG_WIDTH'(in_data[IN_GEN_LO +: TAG_FIELD_W]);
  assign req_sequence   = TAG_WIDTH'(in_data[IN_SEQ_LO +: TAG_FIELD_W]);
  assign req_level      = LEVEL_WIDTH'(in_data[IN_LEVEL_LO +: LEVEL_FLD_W]);
  assign req_kind       = in_data[IN_KIND_LO +: KIND_W];
  assign req_spare      = in_data[IN_SPARE_LO +: SPARE_W];
  assign req_status     = in_data[IN_STATUS_LO +: STATUS_W];
  assign req_stat_sel   = in_data[IN_STSEL_LO +: STAT_SEL_W];

  // Slots
  logic                   pending_flag;
  logic [TAG_WIDTH-1:0]   pend_session;
  logic [TAG_WIDTH-1:0]   pend_request;
  logic [TAG_WIDTH-1:0]   pend_generation;
  logic [TAG_WIDTH-1:0]   pend_sequence;
  logic [LEVEL_WIDTH-1:0] pend_level;
  logic                   pend_kind;
  logic                   flight_flag;
  logic [TAG_WIDTH-1:0]   flt_session;
  logic [TAG_WIDTH-1:0]   flt_request;
  logic [TAG_WIDTH-1:0]   flt_generation;
  logic [TAG_WIDTH-1:0]   flt_sequence;
  logic [TAG_WIDTH-1:0]   last_seq;

  // Counters
  logic [NUM_CNT-1:0]     cnt_inc;
  logic [COUNT_WIDTH-1:0] cnt_val [NUM_CNT];

  crm_counters #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_counters (
    .clk   (clk),
    .rst   (rst),
    .inc   (cnt_inc),
    .count (cnt_val)
  );

  // Decision logic
  logic       post_ok;
  logic       is_stale;
  logic       flight_match;
  logic       status_ok;
  logic [3:0] apply_inc;

  assign post_ok = (req_session != '0) && (req_request != '0) &&
                   (req_generation != '0) && (req_sequence != '0) &&
                   (req_level >= level_min) && (req_level <= level_max) &&
                   !req_kind[1] && (req_spare == '0);
  assign is_stale     = req_sequence <= last_seq;
  assign flight_match = flight_flag && (req_sequence == flt_sequence) &&
                        (req_session == flt_session) && (req_request == flt_request) &&
                        (req_generation == flt_generation);
  assign status_ok    = !req_status[2];
  assign apply_inc    = 4'b0001 << req_status[1:0];

  result_t               code_next;
  logic                  ev_next;
  logic                  ret_pending;
  logic                  load_pending;
  logic                  take;
  logic                  finish;
  logic [STAT_VAL_W-1:0] stat_next;

  always_comb begin
    code_next    = RES_INVALID;
    ev_next      = 1'b0;
    ret_pending  = 1'b0;
    load_pending = 1'b0;
    take         = 1'b0;
    finish       = 1'b0;
    stat_next    = '0;
    cnt_inc      = '0;
    case (action_t'(req_action))
      ACT_POST: begin
        if (!post_ok) begin
          code_next = RES_INVALID;
        end else if (is_stale) begin
          code_next          = RES_STALE;
          cnt_inc[CNT_STALE] = 1'b1;
        end else begin
          load_pending        = 1'b1;
          cnt_inc[CNT_POSTED] = 1'b1;
          if (pending_flag) begin
            code_next             = RES_REPLACED;
            ev_next               = 1'b1;
            ret_pending           = 1'b1;
            cnt_inc[CNT_REPLACED] = 1'b1;
          end else begin
            code_next = RES_ACCEPTED;
          end
        end
      end
      ACT_TAKE: begin
        if (flight_flag) begin
          code_next = RES_BUSY;
        end else if (!pending_flag) begin
          code_next = RES_EMPTY;
        end else begin
          code_next          = RES_READY;
          ev_next            = 1'b1;
          ret_pending        = 1'b1;
          take               = 1'b1;
          cnt_inc[CNT_TAKEN] = 1'b1;
        end
      end
      ACT_COMPLETE: begin
        if (flight_match && status_ok) begin
          code_next                       = RES_TRUE;
          finish                          = 1'b1;
          cnt_inc[CNT_COMPLETED]          = 1'b1;
          cnt_inc[CNT_FAILED:CNT_OK]      = apply_inc;
        end else begin
          code_next = RES_FALSE;
        end
      end
      ACT_CHECK: begin
        code_next = flight_match ? RES_TRUE : RES_FALSE;
      end
      ACT_NOTE: begin
        if (status_ok) begin
          code_next                  = RES_TRUE;
          cnt_inc[CNT_FAILED:CNT_OK] = apply_inc;
        end else begin
          code_next = RES_FALSE;
        end
      end
      ACT_STAT: begin
        code_next = RES_STAT;
        case (stat_sel_t'(req_stat_sel))
          ST_PENDING:   stat_next = STAT_VAL_W'(pending_flag);
          ST_FLIGHT:    stat_next = STAT_VAL_W'(flight_flag);
          ST_LAST_SEQ:  stat_next = STAT_VAL_W'(last_seq);
          ST_POSTED:    stat_next = STAT_VAL_W'(cnt_val[CNT_POSTED]);
          ST_REPLACED:  stat_next = STAT_VAL_W'(cnt_val[CNT_REPLACED]);
          ST_STALE:     stat_next = STAT_VAL_W'(cnt_val[CNT_STALE]);
          ST_TAKEN:     stat_next = STAT_VAL_W'(cnt_val[CNT_TAKEN]);
          ST_COMPLETED: stat_next = STAT_VAL_W'(cnt_val[CNT_COMPLETED]);
          ST_OK:        stat_next = STAT_VAL_W'(cnt_val[CNT_OK]);
          ST_BUSY:      stat_next = STAT_VAL_W'(cnt_val[CNT_BUSY]);
          ST_TIMEOUT:   stat_next = STAT_VAL_W'(cnt_val[CNT_TIMEOUT]);
          ST_FAILED:    stat_next = STAT_VAL_W'(cnt_val[CNT_FAILED]);
          default:      stat_next = '0;
        endcase
      end
      default: begin
        code_next = RES_INVALID;
      end
    endcase
    if (!advance) begin
      cnt_inc = '0;
    end
  end

  // Slot state
  always_ff @(posedge clk) begin
    if (rst) begin
      pending_flag <= 1'b0;
      flight_flag  <= 1'b0;
      last_seq     <= '0;
    end else if (advance) begin
      if (load_pending) begin
        pending_flag <= 1'b1;
        last_seq     <= req_sequence;
      end else if (take) begin
        pending_flag <= 1'b0;
        flight_flag  <= 1'b1;
      end else if (finish) begin
        flight_flag <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && load_pending) begin
      pend_session    <= req_session;
      pend_request    <= req_request;
      pend_generation <= req_generation;
      pend_sequence   <= req_sequence;
      pend_level      <= req_level;
      pend_kind       <= req_kind[0];
    end
    if (advance && take) begin
      flt_session    <= pend_session;
      flt_request    <= pend_request;
      flt_generation <= pend_generation;
      flt_sequence   <= pend_sequence;
    end
  end

  // Result register
  result_t                out_code;
  logic                   out_ev;
  logic [TAG_FIELD_W-1:0] out_session;
  logic [TAG_FIELD_W-1:0] out_request;
  logic [TAG_FIELD_W-1:0] out_generation;
  logic [TAG_FIELD_W-1:0] out_sequence;
  logic [LEVEL_FLD_W-1:0] out_level;
  logic                   out_kind;
  logic [STAT_VAL_W-1:0]  out_stat;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_code <= code_next;
      out_ev   <= ev_next;
      out_stat <= stat_next;
      if (ret_pending) begin
        out_session    <= TAG_FIELD_W'(pend_session);
        out_request    <= TAG_FIELD_W'(pend_request);
        out_generation <= TAG_FIELD_W'(pend_generation);
        out_sequence   <= TAG_FIELD_W'(pend_sequence);
        out_level      <= LEVEL_FLD_W'(pend_level);
        out_kind       <= pend_kind;
      end else begin
        out_session    <= '0;
        out_request    <= '0;
        out_generation <= '0;
        out_sequence   <= '0;
        out_level      <= '0;
        out_kind       <= 1'b0;
      end
    end
  end

  assign m_tuser = out_ev;
  assign m_tdata = {{OUT_PAD_W{1'b0}}, out_stat, out_kind, out_level, out_sequence,
                    out_generation, out_request, out_session, out_code};

endmodule

// ----- tb/coalescing_request_mailbox_tb.sv -----
// Self-checking testbench for coalescing_request_mailbox: drives commands on the stream port,
// predicts each result from an in-bench model of the mailbox and scoreboards the output.
// Depends on crm_pkg and the coalescing_request_mailbox RTL.
module coalescing_request_mailbox_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import crm_pkg::*;

  localparam int DUT_LATENCY     = 2;
  localparam int WATCHDOG_CYCLES = 4000;
  localparam int MAX_REPORTS     = 200;
  localparam int RANDOM_PHASES   = 4;
  localparam int PHASE_ITEMS     = 300;

  localparam logic [ACTION_W-1:0] ACT_RSVD6    = 3'd6;
  localparam logic [ACTION_W-1:0] ACT_RSVD7    = 3'd7;
  localparam logic [KIND_W-1:0]   KIND_PREVIEW = 2'd0;
  localparam logic [KIND_W-1:0]   KIND_FINAL   = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_OK    = 3'd0;
  localparam logic [STATUS_W-1:0] STATUS_BUSY  = 3'd1;
  localparam logic [STATUS_W-1:0] STATUS_TMO   = 3'd2;
  localparam logic [STATUS_W-1:0] STATUS_FAIL  = 3'd3;
  localparam logic [STATUS_W-1:0] STATUS_BAD   = 3'd4;

  localparam int OUT_SESS_LO  = RESULT_W;
  localparam int OUT_REQ_LO   = OUT_SESS_LO + TAG_FIELD_W;
  localparam int OUT_GEN_LO   = OUT_REQ_LO + TAG_FIELD_W;
  localparam int OUT_SEQ_LO   = OUT_GEN_LO + TAG_FIELD_W;
  localparam int OUT_LEVEL_LO = OUT_SEQ_LO + TAG_FIELD_W;
  localparam int OUT_KIND_LO  = OUT_LEVEL_LO + LEVEL_FLD_W;
  localparam int OUT_STAT_LO  = OUT_KIND_LO + 1;

  typedef struct packed {
    logic [ACTION_W-1:0]    action;
    logic [TAG_FIELD_W-1:0] session;
    logic [TAG_FIELD_W-1:0] request;
    logic [TAG_FIELD_W-1:0] generation;
    logic [TAG_FIELD_W-1:0] seq_no;
    logic [LEVEL_FLD_W-1:0] level;
    logic [KIND_W-1:0]      kind;
    logic [SPARE_W-1:0]     spare;
    logic [STATUS_W-1:0]    status;
    logic [STAT_SEL_W-1:0]  stat_sel;
  } cmd_t;

  typedef struct packed {
    logic [TAG_FIELD_W-1:0] session;
    logic [TAG_FIELD_W-1:0] request;
    logic [TAG_FIELD_W-1:0] generation;
    logic [TAG_FIELD_W-1:0] seq_no;
    logic [LEVEL_FLD_W-1:0] level;
    logic                   kind;
  } slot_t;

  typedef struct packed {
    logic [RESULT_W-1:0]   code;
    logic                  entry_valid;
    slot_t                 entry;
    logic [STAT_VAL_W-1:0] stat;
  } mbox_result_t;

  logic clk = 1'b0;
  logic rst;
  logic s_tvalid;
  logic s_tready;
  logic [S_TDATA_W-1:0] s_tdata;
  logic m_tvalid;
  logic m_tready;
  logic [M_TDATA_W-1:0] m_tdata;
  logic m_tuser;
  logic psel;
  logic penable;
  logic pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic pready;

  coalescing_request_mailbox u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // mailbox model state
  logic [LEVEL_FLD_W-1:0] lvl_min = '0;
  logic [LEVEL_FLD_W-1:0] lvl_max = 8'd255;
  slot_t                  pend_slot = '0;
  logic                   pend_valid = 1'b0;
  slot_t                  flight_slot = '0;
  logic                   flight_valid = 1'b0;
  logic [TAG_FIELD_W-1:0] last_seq = '0;
  logic [31:0]            event_counts [NUM_CNT];

  mbox_result_t expected_results [$];
  int errors = 0;
  int burst_left = 0;

  initial begin
    for (int i = 0; i < NUM_CNT; i++) event_counts[i] = '0;
  end

  function automatic void bump(int idx);
    if (event_counts[idx] != '1) event_counts[idx] += 1;
  endfunction

  function automatic bit tally_status(logic [STATUS_W-1:0] st);
    if (st > STATUS_FAIL) return 1'b0;
    bump(int'(CNT_OK) + int'(st));
    return 1'b1;
  endfunction

  function automatic mbox_result_t mailbox_predict(cmd_t c);
    mbox_result_t r;
    logic match;
    r = '0;
    r.code = RES_INVALID;
    match = flight_valid && c.seq_no == flight_slot.seq_no &&
            c.session == flight_slot.session && c.request == flight_slot.request &&
            c.generation == flight_slot.generation;
    case (c.action)
      ACT_POST: begin
        if (c.session == '0 || c.request == '0 || c.generation == '0 || c.seq_no == '0 ||
            c.level < lvl_min || c.level > lvl_max || c.kind > KIND_FINAL || c.spare != '0) begin
          r.code = RES_INVALID;
        end else if (c.seq_no <= last_seq) begin
          bump(CNT_STALE);
          r.code = RES_STALE;
        end else begin
          if (pend_valid) begin
            r.entry_valid = 1'b1;
            r.entry = pend_slot;
            r.code = RES_REPLACED;
            bump(CNT_REPLACED);
          end else begin
            r.code = RES_ACCEPTED;
          end
          pend_slot = '{c.session, c.request, c.generation, c.seq_no, c.level, c.kind[0]};
          pend_valid = 1'b1;
          last_seq = c.seq_no;
          bump(CNT_POSTED);
        end
      end
      ACT_TAKE: begin
        if (flight_valid) begin
          r.code = RES_BUSY;
        end else if (!pend_valid) begin
          r.code = RES_EMPTY;
        end else begin
          flight_slot = pend_slot;
          flight_valid = 1'b1;
          pend_slot = '0;
          pend_valid = 1'b0;
          r.entry_valid = 1'b1;
          r.entry = flight_slot;
          r.code = RES_READY;
          bump(CNT_TAKEN);
        end
      end
      ACT_CHECK: r.code = match ? RES_TRUE : RES_FALSE;
      ACT_COMPLETE: begin
        if (!match || c.status > STATUS_FAIL) begin
          r.code = RES_FALSE;
        end else begin
          flight_slot = '0;
          flight_valid = 1'b0;
          bump(CNT_COMPLETED);
          void'(tally_status(c.status));
          r.code = RES_TRUE;
        end
      end
      ACT_NOTE: r.code = tally_status(c.status) ? RES_TRUE : RES_FALSE;
      ACT_STAT: begin
        r.code = RES_STAT;
        case (c.stat_sel)
          ST_PENDING:   r.stat = {31'b0, pend_valid};
          ST_FLIGHT:    r.stat = {31'b0, flight_valid};
          ST_LAST_SEQ:  r.stat = last_seq;
          ST_POSTED:    r.stat = event_counts[CNT_POSTED];
          ST_REPLACED:  r.stat = event_counts[CNT_REPLACED];
          ST_STALE:     r.stat = event_counts[CNT_STALE];
          ST_TAKEN:     r.stat = event_counts[CNT_TAKEN];
          ST_COMPLETED: r.stat = event_counts[CNT_COMPLETED];
          ST_OK:        r.stat = event_counts[CNT_OK];
          ST_BUSY:      r.stat = event_counts[CNT_BUSY];
          ST_TIMEOUT:   r.stat = event_counts[CNT_TIMEOUT];
          ST_FAILED:    r.stat = event_counts[CNT_FAILED];
          default:      r.stat = '0;
        endcase
      end
      default: r.code = RES_INVALID;
    endcase
    return r;
  endfunction

  function automatic logic [S_TDATA_W-1:0] pack_cmd(cmd_t c);
    logic [S_TDATA_W-1:0] d;
    d = '0;
    d[IN_ACTION_LO +: ACTION_W]    = c.action;
    d[IN_SESS_LO   +: TAG_FIELD_W] = c.session;
    d[IN_REQ_LO    +: TAG_FIELD_W] = c.request;
    d[IN_GEN_LO    +: TAG_FIELD_W] = c.generation;
    d[IN_SEQ_LO    +: TAG_FIELD_W] = c.seq_no;
    d[IN_LEVEL_LO  +: LEVEL_FLD_W] = c.level;
    d[IN_KIND_LO   +: KIND_W]      = c.kind;
    d[IN_SPARE_LO  +: SPARE_W]     = c.spare;
    d[IN_STATUS_LO +: STATUS_W]    = c.status;
    d[IN_STSEL_LO  +: STAT_SEL_W]  = c.stat_sel;
    return d;
  endfunction

  function automatic cmd_t blank_cmd(logic [ACTION_W-1:0] act);
    cmd_t c;
    c = '0;
    c.action = act;
    return c;
  endfunction

  function automatic cmd_t post_cmd(logic [TAG_FIELD_W-1:0] seq, logic [LEVEL_FLD_W-1:0] lvl,
                                    logic [KIND_W-1:0] knd);
    cmd_t c;
    c = blank_cmd(ACT_POST);
    c.session    = $urandom() | 32'd1;
    c.request    = $urandom() | 32'd1;
    c.generation = $urandom() | 32'd1;
    c.seq_no     = seq;
    c.level      = lvl;
    c.kind       = knd;
    return c;
  endfunction

  function automatic cmd_t flight_cmd(logic [ACTION_W-1:0] act, logic [STATUS_W-1:0] st);
    cmd_t c;
    c = blank_cmd(act);
    c.session    = flight_slot.session;
    c.request    = flight_slot.request;
    c.generation = flight_slot.generation;
    c.seq_no     = flight_slot.seq_no;
    c.status     = st;
    return c;
  endfunction

  function automatic cmd_t stat_cmd(logic [STAT_SEL_W-1:0] sel);
    cmd_t c;
    c = blank_cmd(ACT_STAT);
    c.stat_sel = sel;
    return c;
  endfunction

  // one command transfer; sender runs in bursts with random gaps
  task automatic send_cmd(input cmd_t c);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150) : $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata  <= pack_cmd(c);
    do @(posedge clk); while (s_tready !== 1'b1);
    expected_results.push_back(mailbox_predict(c));
  endtask

  task automatic wait_for_results;
    s_tvalid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (expected_results.size() != 0);
    repeat (DUT_LATENCY) @(posedge clk);
  endtask

  task automatic apb_write(cfg_reg_t idx, logic [LEVEL_FLD_W-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CFG_ADDR_W'(int'(idx) * 4);
    pwdata  <= ($urandom() & 32'hFFFF_FF00) | 32'(val);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_LEVEL_MIN) lvl_min = val;
    else lvl_max = val;
    @(posedge clk);
  endtask

  task automatic set_level_bounds(logic [LEVEL_FLD_W-1:0] lo, logic [LEVEL_FLD_W-1:0] hi);
    wait_for_results();
    apb_write(REG_LEVEL_MIN, lo);
    apb_write(REG_LEVEL_MAX, hi);
  endtask

  task automatic test_basic_ops;
    cmd_t c;
    send_cmd(stat_cmd(ST_PENDING));
    send_cmd(blank_cmd(ACT_TAKE));
    c = post_cmd(32'd5, 8'd10, KIND_PREVIEW); c.session = '0;    send_cmd(c);
    c = post_cmd(32'd5, 8'd10, KIND_PREVIEW); c.request = '0;    send_cmd(c);
    c = post_cmd(32'd5, 8'd10, KIND_PREVIEW); c.generation = '0; send_cmd(c);
    send_cmd(post_cmd(32'd0, 8'd10, KIND_PREVIEW));
    send_cmd(post_cmd(32'd5, 8'd10, 2'd2));
    c = post_cmd(32'd5, 8'd10, KIND_FINAL); c.spare = 8'h80;     send_cmd(c);
    send_cmd(post_cmd(32'd10, 8'd0, KIND_PREVIEW));
    send_cmd(post_cmd(32'd10, 8'd50, KIND_FINAL));
    send_cmd(post_cmd(32'd12, 8'd255, KIND_FINAL));
    send_cmd(blank_cmd(ACT_TAKE));
    send_cmd(blank_cmd(ACT_TAKE));
    send_cmd(post_cmd(32'd13, 8'd77, KIND_PREVIEW));
    send_cmd(blank_cmd(ACT_TAKE));
    send_cmd(flight_cmd(ACT_CHECK, STATUS_OK));
    c = flight_cmd(ACT_CHECK, STATUS_OK); c.request ^= 32'd1;    send_cmd(c);
    send_cmd(flight_cmd(ACT_COMPLETE, STATUS_BAD));
    c = flight_cmd(ACT_COMPLETE, STATUS_OK); c.seq_no += 32'd1;  send_cmd(c);
    send_cmd(flight_cmd(ACT_COMPLETE, STATUS_BUSY));
    c = blank_cmd(ACT_NOTE); c.status = STATUS_FAIL;             send_cmd(c);
    c = blank_cmd(ACT_NOTE); c.status = 3'd7;                    send_cmd(c);
    send_cmd(blank_cmd(ACT_RSVD6));
    send_cmd(blank_cmd(ACT_RSVD7));
    send_cmd(stat_cmd(4'd13));
  endtask

  task automatic test_level_bounds;
    set_level_bounds(8'd10, 8'd20);
    send_cmd(post_cmd(last_seq + 32'd1, 8'd9, KIND_PREVIEW));
    send_cmd(post_cmd(last_seq + 32'd1, 8'd10, KIND_PREVIEW));
    send_cmd(post_cmd(last_seq + 32'd1, 8'd20, KIND_FINAL));
    send_cmd(post_cmd(last_seq + 32'd1, 8'd21, KIND_FINAL));
    set_level_bounds(8'd0, 8'd0);
    send_cmd(post_cmd(last_seq + 32'd1, 8'd0, KIND_PREVIEW));
    send_cmd(post_cmd(last_seq + 32'd1, 8'd1, KIND_PREVIEW));
    set_level_bounds(8'd255, 8'd255);
    send_cmd(post_cmd(last_seq + 32'd1, 8'd255, KIND_FINAL));
    send_cmd(post_cmd(last_seq + 32'd1, 8'd254, KIND_FINAL));
    // crossed bounds reject every post
    set_level_bounds(8'd200, 8'd100);
    send_cmd(post_cmd(last_seq + 32'd1, 8'd150, KIND_FINAL));
    send_cmd(post_cmd(last_seq + 32'd1, 8'd200, KIND_FINAL));
  endtask

  task automatic test_random_traffic;
    cmd_t c;
    int pick;
    int k;
    logic [LEVEL_FLD_W-1:0] lvl;
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      if (ph == 0) set_level_bounds(8'd0, 8'd255);
      else set_level_bounds($urandom_range(0, 100), $urandom_range(150, 255));
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        pick = $urandom_range(0, 99);
        k = $urandom_range(0, 31);
        lvl = $urandom_range(int'(lvl_min), int'(lvl_max));
        if (pick < 30) begin
          c = post_cmd(last_seq + $urandom_range(1, 4), lvl, $urandom_range(0, 1));
        end else if (pick < 36) begin
          c = post_cmd(last_seq + 32'd1, lvl, $urandom_range(0, 1));
          case ($urandom_range(0, 4))
            0: c.seq_no = $urandom_range(0, last_seq);
            1: begin
              c.seq_no = $urandom();
              case ($urandom_range(0, 2))
                0: c.session = '0;
                1: c.request = '0;
                default: c.generation = '0;
              endcase
            end
            2: c.kind = $urandom_range(2, 3);
            3: c.spare = $urandom_range(1, 255);
            default: c.level = lvl_max + 8'd1;
          endcase
        end else if (pick < 56) begin
          c = blank_cmd(ACT_TAKE);
        end else if (pick < 78) begin
          c = flight_cmd((pick < 70) ? ACT_COMPLETE : ACT_CHECK,
                         ($urandom_range(0, 9) == 0) ? $urandom_range(4, 7) : $urandom_range(0, 3));
          if ($urandom_range(0, 4) == 0) begin
            case ($urandom_range(0, 3))
              0: c.session ^= 32'd1 << k;
              1: c.request ^= 32'd1 << k;
              2: c.generation ^= 32'd1 << k;
              default: c.seq_no ^= 32'd1 << k;
            endcase
          end
        end else if (pick < 83) begin
          c = blank_cmd(ACT_NOTE);
          c.status = $urandom_range(0, 7);
        end else if (pick < 90) begin
          c = stat_cmd($urandom_range(0, 15));
        end else begin
          c.action     = $urandom_range(0, 7);
          c.session    = $urandom();
          c.request    = $urandom();
          c.generation = $urandom();
          c.seq_no     = $urandom() >> 1;
          c.level      = $urandom();
          c.kind       = $urandom();
          c.spare      = $urandom();
          c.status     = $urandom();
          c.stat_sel   = $urandom();
        end
        send_cmd(c);
      end
    end
  endtask

  task automatic test_sequence_limit;
    cmd_t c;
    set_level_bounds(8'd0, 8'd255);
    c = post_cmd(32'hFFFF_FFFF, 8'd255, KIND_FINAL);
    c.session = '1; c.request = '1; c.generation = '1;
    send_cmd(c);
    send_cmd(post_cmd(32'hFFFF_FFFF, 8'd1, KIND_PREVIEW));
    send_cmd(post_cmd(32'hFFFF_FFF0, 8'd1, KIND_PREVIEW));
    send_cmd(stat_cmd(ST_LAST_SEQ));
    send_cmd(flight_cmd(ACT_COMPLETE, STATUS_TMO));
    send_cmd(blank_cmd(ACT_TAKE));
    send_cmd(flight_cmd(ACT_COMPLETE, STATUS_OK));
    send_cmd(stat_cmd(ST_COMPLETED));
    send_cmd(stat_cmd(ST_STALE));
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      errors++;
      if (errors <= MAX_REPORTS)
        $display("%0t: %s expected %h got %h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : result_check
    mbox_result_t want;
    if (!rst && m_tvalid === 1'b1 && m_tready === 1'b1) begin
      if (expected_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result transfer, expected none got %h", $time, m_tdata);
      end else begin
        want = expected_results.pop_front();
        check_field("result_code", want.code, m_tdata[0 +: RESULT_W]);
        check_field("entry_valid", want.entry_valid, m_tuser);
        check_field("out_session", want.entry.session, m_tdata[OUT_SESS_LO +: TAG_FIELD_W]);
        check_field("out_request", want.entry.request, m_tdata[OUT_REQ_LO +: TAG_FIELD_W]);
        check_field("out_generation", want.entry.generation, m_tdata[OUT_GEN_LO +: TAG_FIELD_W]);
        check_field("out_sequence", want.entry.seq_no, m_tdata[OUT_SEQ_LO +: TAG_FIELD_W]);
        check_field("out_level", want.entry.level, m_tdata[OUT_LEVEL_LO +: LEVEL_FLD_W]);
        check_field("out_kind", want.entry.kind, m_tdata[OUT_KIND_LO]);
        check_field("stat_value", want.stat, m_tdata[OUT_STAT_LO +: STAT_VAL_W]);
      end
    end
  end

  // receiver backpressure: ready pattern from a randomly chosen mode
  always @(posedge clk) begin : sink_stall
    int mode;
    int left;
    if (left <= 0) begin
      mode = $urandom_range(0, 3);
      left = $urandom_range(20, 120);
    end
    left--;
    case (mode)
      0: m_tready <= 1'b1;
      1: m_tready <= $urandom_range(0, 1);
      2: m_tready <= ($urandom_range(0, 3) == 0);
      default: m_tready <= ((left % 13) < 9);
    endcase
  end

  always @(posedge clk) begin : watchdog
    int quiet;
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
    else quiet++;
    if (quiet >= WATCHDOG_CYCLES) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    m_tready = 1'b0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_basic_ops();
    test_level_bounds();
    test_random_traffic();
    test_sequence_limit();
    wait_for_results();
    repeat (4 * DUT_LATENCY) @(posedge clk);
    if (errors == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ----- files.f -----
sv/crm_pkg.sv
sv/crm_counters.sv
sv/coalescing_request_mailbox.sv
tb/coalescing_request_mailbox_tb.sv
